/* sv/dldf_pkg.sv */
`default_nettype none
package dldf_pkg;

    localparam int MAX_CORES         = 64;
    localparam int MAX_ELEMENT_NODES = 1024;
    localparam int CNT_W             = $clog2(MAX_CORES + 1);
    localparam int NODE_W            = $clog2(MAX_ELEMENT_NODES + 1);
    localparam int SUM_W             = 42;
    localparam int MUL_W             = 40;
    localparam int STEPS             = 30;

    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] INV_2PI_Q30 = 64'sd170891319;
    localparam logic signed [63:0] LN2_Q30     = 64'sd744261118;
    localparam logic signed [63:0] INV_GAIN    = 64'sd652032874;

    localparam logic [2:0] CFG_CORE_START = 3'd0;
    localparam logic [2:0] CFG_CORE_STEP  = 3'd1;
    localparam logic [2:0] CFG_BURGERS    = 3'd2;
    localparam logic [2:0] CFG_POISSON    = 3'd3;
    localparam logic [2:0] CFG_ROTATION   = 3'd4;
    localparam logic [2:0] CFG_MIRROR     = 3'd5;
    localparam logic [2:0] CFG_CORE_COUNT = 3'd6;
    localparam logic [2:0] CFG_FIELD_MODE = 3'd7;

    typedef enum logic [5:0] {
        S_IDLE, S_INV, S_INVW, S_KB, S_KS, S_KS2, S_ROW, S_SC, S_CORD, S_CPOST,
        S_CORE, S_P1, S_P2, S_P3, S_P4, S_P5, S_CHK, S_NRM, S_MAG, S_MAG2,
        S_NRM2, S_LOGM, S_LOGC, S_L1, S_L2, S_L3,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
        S_M11, S_M12, S_M13, S_M14, S_M15, S_NEXT, S_RDONE, S_FIN,
        S_DIV, S_DIVW, S_OUT
    } t_state;

    typedef enum logic [1:0] {CP_FRAME, CP_POLAR, CP_THETA} t_cph;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int unsigned k);
        logic signed [63:0] half;
        half = 64'sd1 <<< (k - 1);
        return (v + half) >>> k;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] wrap_angle(input logic signed [63:0] v);
        logic signed [63:0] a;
        a = v;
        for (int k = 0; k < 4; k++) begin
            if (a > PI_Q30) begin
                a = a - TWO_PI_Q30;
            end else if (a < -PI_Q30) begin
                a = a + TWO_PI_Q30;
            end
        end
        return a;
    endfunction

    function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
        logic signed [63:0] r;
        case (i)
            5'd0:  r = 64'sh3243F6A8;
            5'd1:  r = 64'sh1DAC6705;
            5'd2:  r = 64'sh0FADBAFC;
            5'd3:  r = 64'sh07F56EA6;
            5'd4:  r = 64'sh03FEAB76;
            5'd5:  r = 64'sh01FFD55B;
            5'd6:  r = 64'sh00FFFAAA;
            5'd7:  r = 64'sh007FFF55;
            5'd8:  r = 64'sh003FFFEA;
            5'd9:  r = 64'sh001FFFFD;
            5'd10: r = 64'sh000FFFFF;
            5'd11: r = 64'sh0007FFFF;
            5'd12: r = 64'sh0003FFFF;
            5'd13: r = 64'sh0001FFFF;
            5'd14: r = 64'sh0000FFFF;
            5'd15: r = 64'sh00007FFF;
            5'd16: r = 64'sh00003FFF;
            5'd17: r = 64'sh00001FFF;
            5'd18: r = 64'sh00000FFF;
            5'd19: r = 64'sh000007FF;
            5'd20: r = 64'sh000003FF;
            5'd21: r = 64'sh000001FF;
            5'd22: r = 64'sh000000FF;
            5'd23: r = 64'sh0000007F;
            5'd24: r = 64'sh0000003F;
            5'd25: r = 64'sh0000001F;
            5'd26: r = 64'sh0000000F;
            5'd27: r = 64'sh00000008;
            5'd28: r = 64'sh00000004;
            5'd29: r = 64'sh00000002;
            default: r = 64'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/dldf_if.sv */
`default_nettype none
interface dldf_node_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic               last_node;
    modport source (output valid, node_x, node_y, node_z, last_node, input ready);
    modport sink (input valid, node_x, node_y, node_z, last_node, output ready);
endinterface

interface dldf_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] moved_x;
    logic signed [31:0] moved_y;
    logic signed [31:0] moved_z;
    logic signed [31:0] centroid_x;
    logic signed [31:0] centroid_y;
    logic signed [31:0] centroid_z;
    logic               centroid_valid;
    logic               on_core;
    modport source (output valid, moved_x, moved_y, moved_z, centroid_x, centroid_y,
                    centroid_z, centroid_valid, on_core, input ready);
    modport sink (input valid, moved_x, moved_y, moved_z, centroid_x, centroid_y,
                  centroid_z, centroid_valid, on_core, output ready);
endinterface

interface dldf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/dldf_div.sv */
`default_nettype none
module dldf_div
    import dldf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_dq, n_dq;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [32:0] w_sh;
    logic [32:0] w_diff;

    always_comb begin
        w_sh   = {r_rem, r_dq[63]};
        w_diff = w_sh - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dq   = r_dq;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dq   = i_req.dividend;
            n_rem  = '0;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_diff[31:0];
                n_dq  = {r_dq[62:0], 1'b1};
            end else begin
                n_rem = w_sh[31:0];
                n_dq  = {r_dq[62:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq  <= n_dq;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dq;

endmodule
`default_nettype wire

/* sv/dislocation_displacement_field_core.sv */
`default_nettype none
// One node word is taken when the block is idle; the next is taken after its result is stored.
// Each node is processed over R rows (1 or 2) with K cores per row, and the last node
// also computes the centroid. The shared CORDIC stage, the log squaring through the one
// multiplier and the bit-serial divider set the run time.
// Synchronous active-low reset clears the control, the registers to their reset values,
// the element sums and the node count.
module dislocation_displacement_field_core
    import dldf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dldf_node_if.sink i_node,
    dldf_res_if.source o_res,
    dldf_cfg_if.sink  i_cfg
);

    t_state r_state, n_state;
    t_cph   r_cph, n_cph;

    logic [63:0]        r_cs, r_cstep, r_burg, r_mir;
    logic [14:0]        r_nu;
    logic signed [30:0] r_rot;
    logic [6:0]         r_ccnt;
    logic               r_mode;

    logic signed [31:0] r_nx, r_ny, r_nz, n_nx, n_ny, n_nz;
    logic               r_last, n_last;
    logic signed [63:0] r_inv, n_inv, r_kb, n_kb, r_ks, n_ks, r_c, n_c, r_s, n_s;
    logic signed [63:0] r_cpx, n_cpx, r_cpy, n_cpy, r_stx, n_stx;
    logic               r_sub, n_sub, r_hit, n_hit, r_neg, n_neg, r_vec, n_vec;
    logic [CNT_W-1:0]   r_n, n_n, r_cnt, n_cnt;
    logic signed [63:0] r_t0, n_t0, r_t1, n_t1, r_t2, n_t2;
    logic signed [31:0] r_dx, n_dx, r_dy, n_dy;
    logic signed [63:0] r_acc, n_acc, r_px, n_px, r_py, n_py, r_th, n_th, r_lnr, n_lnr;
    logic signed [63:0] r_ct, n_ct, r_st, n_st, r_a, n_a, r_b, n_b;
    logic signed [63:0] r_tt1, n_tt1, r_tt2, n_tt2, r_w, n_w, r_r1, n_r1;
    logic signed [31:0] r_u1, n_u1, r_u2, n_u2, r_u3, n_u3;
    logic signed [63:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic [4:0]         r_i, n_i, r_li, n_li;
    logic [63:0]        r_mx, n_mx, r_mg, n_mg;
    logic [5:0]         r_sh, n_sh;
    logic signed [7:0]  r_p, n_p;
    logic [29:0]        r_frac, n_frac;
    logic signed [63:0] r_prod;
    logic signed [SUM_W-1:0] r_sumx, n_sumx, r_sumy, n_sumy, r_sumz, n_sumz;
    logic [NODE_W-1:0]  r_cntn, n_cntn;
    logic signed [31:0] r_mvx, n_mvx, r_mvy, n_mvy, r_mvz, n_mvz;
    logic signed [31:0] r_cen [3];
    logic signed [31:0] n_cen [3];
    logic [1:0]         r_ax, n_ax;
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_omx, n_omx, r_omy, n_omy, r_omz, n_omz;
    logic signed [31:0] r_ocx, n_ocx, r_ocy, n_ocy, r_ocz, n_ocz;
    logic               r_ocv, n_ocv, r_ohit, n_ohit;

    logic signed [MUL_W-1:0]   m_a, m_b;
    logic signed [2*MUL_W-1:0] w_prod;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic signed [63:0] w_ang, w_sx, w_sy, w_cdx, w_cdy, w_cdz, w_e, w_z, w_sel;
    logic [63:0]        w_ax, w_ay, w_t;
    logic               w_up, w_free, w_accept;
    logic signed [31:0] w_mx, w_my, w_mz;

    assign w_accept = i_node.valid && i_node.ready;
    assign w_free   = !r_ovalid || o_res.ready;
    assign i_node.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_prod = m_a * m_b;

    dldf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    always_comb begin
        n_state = r_state;  n_cph = r_cph;
        n_nx = r_nx; n_ny = r_ny; n_nz = r_nz; n_last = r_last;
        n_inv = r_inv; n_kb = r_kb; n_ks = r_ks; n_c = r_c; n_s = r_s;
        n_cpx = r_cpx; n_cpy = r_cpy; n_stx = r_stx;
        n_sub = r_sub; n_hit = r_hit; n_neg = r_neg; n_vec = r_vec;
        n_n = r_n; n_cnt = r_cnt; n_t0 = r_t0; n_t1 = r_t1; n_t2 = r_t2;
        n_dx = r_dx; n_dy = r_dy; n_acc = r_acc; n_px = r_px; n_py = r_py;
        n_th = r_th; n_lnr = r_lnr; n_ct = r_ct; n_st = r_st; n_a = r_a; n_b = r_b;
        n_tt1 = r_tt1; n_tt2 = r_tt2; n_w = r_w; n_r1 = r_r1;
        n_u1 = r_u1; n_u2 = r_u2; n_u3 = r_u3;
        n_cx = r_cx; n_cy = r_cy; n_cz = r_cz; n_i = r_i; n_li = r_li;
        n_mx = r_mx; n_mg = r_mg; n_sh = r_sh; n_p = r_p; n_frac = r_frac;
        n_sumx = r_sumx; n_sumy = r_sumy; n_sumz = r_sumz; n_cntn = r_cntn;
        n_mvx = r_mvx; n_mvy = r_mvy; n_mvz = r_mvz; n_ax = r_ax;
        n_cen = r_cen;
        n_ovalid = r_ovalid && !o_res.ready;
        n_omx = r_omx; n_omy = r_omy; n_omz = r_omz;
        n_ocx = r_ocx; n_ocy = r_ocy; n_ocz = r_ocz; n_ocv = r_ocv; n_ohit = r_ohit;
        m_a = '0;
        m_b = '0;
        div_req = '0;
        w_ang = r_sub ? (64'($signed(r_mir[31:0])) <<< 2) : (64'(r_rot) <<< 2);
        w_sx  = r_sub ? 64'($signed(r_mir[63:32])) : 64'($signed(r_cs[63:32]));
        w_sy  = 64'($signed(r_cs[31:0]));
        w_cdx = r_cx >>> r_i;
        w_cdy = r_cy >>> r_i;
        w_up  = r_vec ? r_cy[63] : !r_cz[63];
        w_ax  = r_px[63] ? 64'(-r_px) : 64'(r_px);
        w_ay  = r_py[63] ? 64'(-r_py) : 64'(r_py);
        w_e   = 64'(r_p) - 64'sd16 - 64'($signed({1'b0, r_sh}));
        w_t   = 64'(r_prod) >> 30;
        w_z   = wrap_angle(r_cz);
        w_cdz = r_cz;
        w_mx  = sat32(64'(r_nx) + r_t0);
        w_my  = sat32(64'(r_ny) + r_t1);
        w_mz  = sat32(64'(r_nz) + r_t2);
        unique case (r_ax)
            2'd0:    w_sel = 64'(r_sumx);
            2'd1:    w_sel = 64'(r_sumy);
            default: w_sel = 64'(r_sumz);
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_nx = i_node.node_x;
                    n_ny = i_node.node_y;
                    n_nz = i_node.node_z;
                    n_last = i_node.last_node;
                    n_t0 = '0; n_t1 = '0; n_t2 = '0;
                    n_hit = 1'b0;
                    n_sub = 1'b0;
                    n_state = S_INV;
                end
            end
            S_INV: begin
                div_req.start    = 1'b1;
                div_req.dividend = 64'd1 << 60;
                div_req.divisor  = 32'd1073741824 - {3'd0, r_nu, 14'd0};
                n_state = S_INVW;
            end
            S_INVW: begin
                if (div_rsp.done) begin
                    n_inv = $signed(div_rsp.quot);
                    n_state = S_KB;
                end
            end
            S_KB: begin
                m_a = MUL_W'($signed(r_burg[63:32]));
                m_b = MUL_W'(INV_2PI_Q30);
                n_state = S_KS;
            end
            S_KS: begin
                n_kb = rshr(r_prod, 30);
                m_a = MUL_W'($signed(r_burg[31:0]));
                m_b = MUL_W'(INV_2PI_Q30);
                n_state = S_KS2;
            end
            S_KS2: begin
                n_ks = rshr(r_prod, 30);
                n_state = S_ROW;
            end
            S_ROW: begin
                n_cz  = w_ang;
                n_cpx = w_sx;
                n_cpy = w_sy;
                n_stx = r_sub ? -64'($signed(r_cstep[63:32])) : 64'($signed(r_cstep[63:32]));
                n_n   = '0;
                n_cnt = (r_ccnt > 7'(MAX_CORES)) ? CNT_W'(MAX_CORES) : CNT_W'(r_ccnt);
                n_cph = CP_FRAME;
                n_state = S_SC;
            end
            S_SC: begin
                n_neg = 1'b0;
                n_cz  = w_z;
                if (w_z > HALF_PI_Q30) begin
                    n_cz = w_z - PI_Q30;
                    n_neg = 1'b1;
                end else if (w_z < -HALF_PI_Q30) begin
                    n_cz = w_z + PI_Q30;
                    n_neg = 1'b1;
                end
                n_cx = INV_GAIN;
                n_cy = '0;
                n_i = '0;
                n_vec = 1'b0;
                n_state = S_CORD;
            end
            S_CORD: begin
                if (w_up) begin
                    n_cx = r_cx - w_cdy;
                    n_cy = r_cy + w_cdx;
                    n_cz = r_cz - atan_q30(r_i);
                end else begin
                    n_cx = r_cx + w_cdy;
                    n_cy = r_cy - w_cdx;
                    n_cz = r_cz + atan_q30(r_i);
                end
                n_i = r_i + 5'd1;
                if (r_i == 5'(STEPS - 1)) begin
                    n_state = S_CPOST;
                end
            end
            S_CPOST: begin
                unique case (r_cph)
                    CP_FRAME: begin
                        n_c = r_neg ? -r_cx : r_cx;
                        n_s = r_neg ? -r_cy : r_cy;
                        n_state = (r_cnt == '0) ? S_RDONE : S_CORE;
                    end
                    CP_THETA: begin
                        n_ct = r_neg ? -r_cx : r_cx;
                        n_st = r_neg ? -r_cy : r_cy;
                        n_state = S_M1;
                    end
                    default: begin
                        if (!r_py[63]) begin
                            if (w_cdz < 0) begin
                                w_cdz = '0;
                            end
                            if (w_cdz > PI_Q30) begin
                                w_cdz = PI_Q30;
                            end
                        end else begin
                            if (w_cdz < 0) begin
                                w_cdz = w_cdz + TWO_PI_Q30;
                            end
                            if (w_cdz < PI_Q30) begin
                                w_cdz = PI_Q30;
                            end
                            if (w_cdz > TWO_PI_Q30 - 64'sd1) begin
                                w_cdz = TWO_PI_Q30 - 64'sd1;
                            end
                        end
                        n_th = w_cdz;
                        n_state = S_MAG;
                    end
                endcase
            end
            S_CORE: begin
                n_dx = sat32(64'(r_nx) - r_cpx);
                n_dy = sat32(64'(r_ny) - r_cpy);
                n_state = S_P1;
            end
            S_P1: begin
                m_a = MUL_W'(r_dx); m_b = MUL_W'(r_c);
                n_state = S_P2;
            end
            S_P2: begin
                n_acc = r_prod;
                m_a = MUL_W'(r_dy); m_b = MUL_W'(r_s);
                n_state = S_P3;
            end
            S_P3: begin
                n_px = rshr(r_acc + r_prod, 30);
                m_a = MUL_W'(r_dy); m_b = MUL_W'(r_c);
                n_state = S_P4;
            end
            S_P4: begin
                n_acc = r_prod;
                m_a = MUL_W'(r_dx); m_b = MUL_W'(r_s);
                n_state = S_P5;
            end
            S_P5: begin
                n_py = rshr(r_acc - r_prod, 30);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_px == '0 && r_py == '0) begin
                    n_hit = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    n_mx = (w_ax > w_ay) ? w_ax : w_ay;
                    n_sh = '0;
                    n_state = S_NRM;
                end
            end
            S_NRM: begin
                if (r_mx[63:50] == '0) begin
                    n_mx = r_mx << 8;
                    n_sh = r_sh + 6'd8;
                end else if (r_mx[63:58] == '0) begin
                    n_mx = r_mx << 1;
                    n_sh = r_sh + 6'd1;
                end else begin
                    n_cx = r_px <<< r_sh;
                    n_cy = r_py <<< r_sh;
                    n_cz = '0;
                    if (r_px[63]) begin
                        n_cx = -(r_px <<< r_sh);
                        n_cy = -(r_py <<< r_sh);
                        n_cz = PI_Q30;
                    end
                    n_i = '0;
                    n_vec = 1'b1;
                    n_cph = CP_POLAR;
                    n_state = S_CORD;
                end
            end
            S_MAG: begin
                m_a = MUL_W'(r_cx >>> 30);
                m_b = MUL_W'(INV_GAIN);
                n_state = S_MAG2;
            end
            S_MAG2: begin
                n_mg = (r_prod == '0) ? 64'd1 : 64'(r_prod);
                n_p = 8'sd30;
                n_state = S_NRM2;
            end
            S_NRM2: begin
                if (r_mg[63:39] != '0) begin
                    n_mg = r_mg >> 8;
                    n_p = r_p + 8'sd8;
                end else if (r_mg[63:31] != '0) begin
                    n_mg = r_mg >> 1;
                    n_p = r_p + 8'sd1;
                end else if (r_mg[63:22] == '0) begin
                    n_mg = r_mg << 8;
                    n_p = r_p - 8'sd8;
                end else if (r_mg[63:30] == '0) begin
                    n_mg = r_mg << 1;
                    n_p = r_p - 8'sd1;
                end else begin
                    n_frac = '0;
                    n_li = '0;
                    n_state = S_LOGM;
                end
            end
            S_LOGM: begin
                m_a = $signed({9'd0, r_mg[30:0]});
                m_b = $signed({9'd0, r_mg[30:0]});
                n_state = S_LOGC;
            end
            S_LOGC: begin
                if (w_t[31]) begin
                    n_mg = w_t >> 1;
                    n_frac = {r_frac[28:0], 1'b1};
                end else begin
                    n_mg = w_t;
                    n_frac = {r_frac[28:0], 1'b0};
                end
                n_li = r_li + 5'd1;
                n_state = (r_li == 5'(STEPS - 1)) ? S_L1 : S_LOGM;
            end
            S_L1: begin
                m_a = $signed({10'd0, r_frac});
                m_b = MUL_W'(LN2_Q30);
                n_state = S_L2;
            end
            S_L2: begin
                n_lnr = rshr(r_prod, 30);
                m_a = MUL_W'(w_e);
                m_b = MUL_W'(LN2_Q30);
                n_state = S_L3;
            end
            S_L3: begin
                n_lnr = r_lnr + r_prod;
                n_cz = r_th;
                n_cph = CP_THETA;
                n_state = S_SC;
            end
            S_M1: begin
                m_a = MUL_W'(r_ct); m_b = MUL_W'(r_st);
                n_state = S_M2;
            end
            S_M2: begin
                n_a = rshr(r_prod, 30);
                m_a = MUL_W'(r_ct); m_b = MUL_W'(r_ct);
                n_state = S_M3;
            end
            S_M3: begin
                n_acc = r_prod;
                m_a = MUL_W'(r_st); m_b = MUL_W'(r_st);
                n_state = S_M4;
            end
            S_M4: begin
                n_b = rshr(r_acc - r_prod, 30);
                m_a = MUL_W'(r_a); m_b = MUL_W'(r_inv);
                n_state = S_M5;
            end
            S_M5: begin
                n_tt1 = r_th + rshr(r_prod, 31);
                m_a = MUL_W'(64'sd65536 - 64'($signed({1'b0, r_nu, 1'b0})));
                m_b = MUL_W'(r_lnr <<< 1);
                n_state = S_M6;
            end
            S_M6: begin
                n_tt2 = rshr(r_prod, 16) + r_b;
                n_state = S_M7;
            end
            S_M7: begin
                m_a = MUL_W'(rshr(r_tt2, 6)); m_b = MUL_W'(r_inv);
                n_state = S_M8;
            end
            S_M8: begin
                n_w = rshr(r_prod, 30);
                m_a = MUL_W'(r_kb); m_b = MUL_W'(r_tt1);
                n_state = S_M9;
            end
            S_M9: begin
                n_u1 = sat32(rshr(r_prod, 30));
                m_a = MUL_W'(r_kb); m_b = MUL_W'(r_w);
                n_state = S_M10;
            end
            S_M10: begin
                n_u2 = sat32(-rshr(r_prod, 26));
                m_a = MUL_W'(r_ks); m_b = MUL_W'(r_th);
                n_state = S_M11;
            end
            S_M11: begin
                n_u3 = sat32(rshr(r_prod, 30));
                m_a = MUL_W'(r_c); m_b = MUL_W'(r_u1);
                n_state = S_M12;
            end
            S_M12: begin
                n_acc = r_prod;
                m_a = MUL_W'(r_s); m_b = MUL_W'(r_u2);
                n_state = S_M13;
            end
            S_M13: begin
                n_r1 = rshr(r_acc - r_prod, 30);
                m_a = MUL_W'(r_c); m_b = MUL_W'(r_u2);
                n_state = S_M14;
            end
            S_M14: begin
                n_acc = r_prod;
                m_a = MUL_W'(r_s); m_b = MUL_W'(r_u1);
                n_state = S_M15;
            end
            S_M15: begin
                if (r_sub) begin
                    n_t0 = r_t0 - r_r1;
                    n_t1 = r_t1 - rshr(r_acc + r_prod, 30);
                    n_t2 = r_t2 - 64'(r_u3);
                end else begin
                    n_t0 = r_t0 + r_r1;
                    n_t1 = r_t1 + rshr(r_acc + r_prod, 30);
                    n_t2 = r_t2 + 64'(r_u3);
                end
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_n = r_n + 1'b1;
                n_cpx = r_cpx + r_stx;
                n_cpy = r_cpy + 64'($signed(r_cstep[31:0]));
                n_state = (r_n + 1'b1 == r_cnt) ? S_RDONE : S_CORE;
            end
            S_RDONE: begin
                if (!r_sub && r_mode) begin
                    n_sub = 1'b1;
                    n_state = S_ROW;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_mvx = w_mx; n_mvy = w_my; n_mvz = w_mz;
                if (r_cntn < NODE_W'(MAX_ELEMENT_NODES)) begin
                    n_sumx = r_sumx + SUM_W'(w_mx);
                    n_sumy = r_sumy + SUM_W'(w_my);
                    n_sumz = r_sumz + SUM_W'(w_mz);
                    n_cntn = r_cntn + 1'b1;
                end
                n_ax = '0;
                n_state = (r_last && n_cntn != '0) ? S_DIV : S_OUT;
            end
            S_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = w_sel[63] ? 64'(-w_sel) : 64'(w_sel);
                div_req.divisor  = 32'(r_cntn);
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    n_cen[r_ax] = w_sel[63] ? -div_rsp.quot[31:0] : div_rsp.quot[31:0];
                    n_ax = r_ax + 2'd1;
                    n_state = (r_ax == 2'd2) ? S_OUT : S_DIV;
                end
            end
            S_OUT: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_omx = r_mvx; n_omy = r_mvy; n_omz = r_mvz;
                    n_ocv = r_last && (r_cntn != '0);
                    n_ocx = n_ocv ? r_cen[0] : '0;
                    n_ocy = n_ocv ? r_cen[1] : '0;
                    n_ocz = n_ocv ? r_cen[2] : '0;
                    n_ohit = r_hit;
                    if (r_last) begin
                        n_sumx = '0; n_sumy = '0; n_sumz = '0;
                        n_cntn = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cph    <= CP_FRAME;
            r_ovalid <= 1'b0;
            r_sumx   <= '0;
            r_sumy   <= '0;
            r_sumz   <= '0;
            r_cntn   <= '0;
            r_cs     <= '0;
            r_cstep  <= '0;
            r_burg   <= '0;
            r_nu     <= 15'd21627;
            r_rot    <= '0;
            r_mir    <= '0;
            r_ccnt   <= 7'd1;
            r_mode   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cph    <= n_cph;
            r_ovalid <= n_ovalid;
            r_sumx   <= n_sumx;
            r_sumy   <= n_sumy;
            r_sumz   <= n_sumz;
            r_cntn   <= n_cntn;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_CORE_START: r_cs    <= i_cfg.data;
                    CFG_CORE_STEP:  r_cstep <= i_cfg.data;
                    CFG_BURGERS:    r_burg  <= i_cfg.data;
                    CFG_POISSON:    r_nu    <= i_cfg.data[14:0];
                    CFG_ROTATION:   r_rot   <= i_cfg.data[30:0];
                    CFG_MIRROR:     r_mir   <= i_cfg.data;
                    CFG_CORE_COUNT: r_ccnt  <= i_cfg.data[6:0];
                    CFG_FIELD_MODE: r_mode  <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx <= n_nx; r_ny <= n_ny; r_nz <= n_nz; r_last <= n_last;
        r_inv <= n_inv; r_kb <= n_kb; r_ks <= n_ks; r_c <= n_c; r_s <= n_s;
        r_cpx <= n_cpx; r_cpy <= n_cpy; r_stx <= n_stx;
        r_sub <= n_sub; r_hit <= n_hit; r_neg <= n_neg; r_vec <= n_vec;
        r_n <= n_n; r_cnt <= n_cnt; r_t0 <= n_t0; r_t1 <= n_t1; r_t2 <= n_t2;
        r_dx <= n_dx; r_dy <= n_dy; r_acc <= n_acc; r_px <= n_px; r_py <= n_py;
        r_th <= n_th; r_lnr <= n_lnr; r_ct <= n_ct; r_st <= n_st; r_a <= n_a; r_b <= n_b;
        r_tt1 <= n_tt1; r_tt2 <= n_tt2; r_w <= n_w; r_r1 <= n_r1;
        r_u1 <= n_u1; r_u2 <= n_u2; r_u3 <= n_u3;
        r_cx <= n_cx; r_cy <= n_cy; r_cz <= n_cz; r_i <= n_i; r_li <= n_li;
        r_mx <= n_mx; r_mg <= n_mg; r_sh <= n_sh; r_p <= n_p; r_frac <= n_frac;
        r_prod <= w_prod[63:0];
        r_mvx <= n_mvx; r_mvy <= n_mvy; r_mvz <= n_mvz; r_ax <= n_ax;
        r_cen <= n_cen;
        r_omx <= n_omx; r_omy <= n_omy; r_omz <= n_omz;
        r_ocx <= n_ocx; r_ocy <= n_ocy; r_ocz <= n_ocz; r_ocv <= n_ocv; r_ohit <= n_ohit;
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.moved_x        = r_omx;
    assign o_res.moved_y        = r_omy;
    assign o_res.moved_z        = r_omz;
    assign o_res.centroid_x     = r_ocx;
    assign o_res.centroid_y     = r_ocy;
    assign o_res.centroid_z     = r_ocz;
    assign o_res.centroid_valid = r_ocv;
    assign o_res.on_core        = r_ohit;

    a_node_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cntn <= NODE_W'(MAX_ELEMENT_NODES))
        else $error("element node count overran its limit");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_INV)
        else $error("accepted node did not start the sequence");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_INVW || r_state == S_DIVW))
        else $error("divider finished outside a wait state");

    a_core_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CORE |-> r_n < r_cnt)
        else $error("core index beyond the row");

    a_centroid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.centroid_valid) |->
        (o_res.centroid_x == 0 && o_res.centroid_y == 0 && o_res.centroid_z == 0))
        else $error("centroid not cleared on an inner node");

endmodule
`default_nettype wire
